FILE: hw/rtl/hhlc_pkg.sv
// package for the http header line checker
// holds the classified byte token, error codes and queue depth; no dependencies
`default_nettype none

package hhlc_pkg;

    localparam int HHLC_QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_REQ_LINE = 2'd1,
        ERR_HDR_LINE = 2'd2,
        ERR_NO_LINES = 2'd3
    } t_err;

    // one input byte reduced to the facts the back end needs
    typedef struct packed {
        logic last;
        logic nul;
        logic eol;
        logic letter;
        logic ws;
        logic colon;
        logic ch_e;
        logic ch_m;
        logic ch_a;
        logic ch_i;
        logic ch_l;
        logic ch_eq;
        logic ch_h;
        logic ch_t;
        logic ch_p;
        logic ch_slash;
        logic ch_one;
    } t_tok;

endpackage

`default_nettype wire

FILE: hw/rtl/http_header_line_checker.sv
// top level of the http header line checker
// instantiates hhlc_front, hhlc_queue and hhlc_back; depends on hhlc_pkg
`default_nettype none

// Checks an HTTP request streamed one byte per word on the slave side and
// gives one verdict word on the master side for each request, on the word
// flagged with tlast. Runs of CR/LF split the text into lines and empty lines
// are skipped. The first line must be letters, whitespace, '/', anything, then
// whitespace and "HTTP/1?1"; each later line passes if it holds "email=" or a
// ':' directly followed by whitespace (space, tab, VT, FF). A NUL byte ends the
// text; later bytes up to tlast are ignored, as are bytes after the first
// error. The verdict holds request_valid and an error code (0 ok, 1 bad
// request line, 2 bad header line, 3 no lines), after which the checker starts
// over for the next request. One byte is taken per clock: the front end
// classifies each byte into a token and pushes it into a small queue, and the
// back end retires one token per cycle unless a verdict waits on the master
// side. The tlast token passes through the queue and then the verdict register.
// When the verdict register is held by a stalled master, up to QueueDepth
// further bytes are still taken before the slave side stalls.
module http_header_line_checker
    import hhlc_pkg::*;
#(
    parameter int QueueDepth = HHLC_QUEUE_DEPTH
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // slave side: request bytes
    input  wire logic       i_s_tvalid,
    output logic            o_s_tready,
    input  wire logic [7:0] i_s_tdata,   // [7:0] data_byte
    input  wire logic       i_s_tlast,   // end_of_request
    // master side: verdicts
    output logic            o_m_tvalid,
    input  wire logic       i_m_tready,
    output logic [7:0]      o_m_tdata    // [0] request_valid, [2:1] error_code, rest zero
);

    // token path from classifier to queue
    logic q_full;
    logic q_push;
    t_tok front_tok;

    // token path from queue to back end
    logic q_valid;
    logic q_pop;
    t_tok q_tok;

    // verdict register outputs
    logic req_valid;
    t_err err_code;

    hhlc_front u_front (
        .i_valid  (i_s_tvalid),
        .i_byte   (i_s_tdata),
        .i_last   (i_s_tlast),
        .i_q_full (q_full),
        .o_ready  (o_s_tready),
        .o_push   (q_push),
        .o_tok    (front_tok)
    );

    hhlc_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_tok   (front_tok),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_tok   (q_tok)
    );

    hhlc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_tok       (q_tok),
        .o_pop       (q_pop),
        .i_out_ready (i_m_tready),
        .o_out_valid (o_m_tvalid),
        .o_req_valid (req_valid),
        .o_err       (err_code)
    );

    // pack verdict, zero fill to a whole byte
    assign o_m_tdata = {5'b00000, err_code, req_valid};

endmodule

`default_nettype wire

FILE: hw/rtl/hhlc_front.sv
// front end: takes input words and classifies each byte into a token
// depends on hhlc_pkg
`default_nettype none

module hhlc_front
    import hhlc_pkg::*;
(
    input  wire logic       i_valid,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_last,
    input  wire logic       i_q_full,
    output logic            o_ready,
    output logic            o_push,
    output t_tok            o_tok
);

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;

    always_comb begin
        o_tok          = '0;
        o_tok.last     = i_last;
        o_tok.nul      = (i_byte == 8'h00);
        o_tok.eol      = (i_byte == 8'h0D) || (i_byte == 8'h0A);
        o_tok.letter   = ((i_byte >= 8'h41) && (i_byte <= 8'h5A))
                      || ((i_byte >= 8'h61) && (i_byte <= 8'h7A));
        o_tok.ws       = (i_byte == 8'h20) || (i_byte == 8'h09)
                      || (i_byte == 8'h0B) || (i_byte == 8'h0C);
        o_tok.colon    = (i_byte == 8'h3A);
        o_tok.ch_e     = (i_byte == 8'h65);
        o_tok.ch_m     = (i_byte == 8'h6D);
        o_tok.ch_a     = (i_byte == 8'h61);
        o_tok.ch_i     = (i_byte == 8'h69);
        o_tok.ch_l     = (i_byte == 8'h6C);
        o_tok.ch_eq    = (i_byte == 8'h3D);
        o_tok.ch_h     = (i_byte == 8'h48);
        o_tok.ch_t     = (i_byte == 8'h54);
        o_tok.ch_p     = (i_byte == 8'h50);
        o_tok.ch_slash = (i_byte == 8'h2F);
        o_tok.ch_one   = (i_byte == 8'h31);
    end

endmodule

`default_nettype wire

FILE: hw/rtl/hhlc_queue.sv
// short token queue between front and back end
// depends on hhlc_pkg
`default_nettype none

module hhlc_queue
    import hhlc_pkg::*;
#(
    parameter int Depth = HHLC_QUEUE_DEPTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_tok i_tok,
    input  wire logic i_pop,
    output logic      o_full,
    output logic      o_valid,
    output t_tok      o_tok
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] LastIdx = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

    t_tok            r_mem [Depth];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [CntW-1:0] r_count;
    logic [PtrW-1:0] n_wr_ptr;
    logic [PtrW-1:0] n_rd_ptr;
    logic [CntW-1:0] n_count;

    assign o_full  = (r_count == FullCnt);
    assign o_valid = (r_count != '0);
    assign o_tok   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LastIdx) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LastIdx) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_tok;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/hhlc_back.sv
// back end: line state machine over tokens and the verdict output register
// depends on hhlc_pkg
`default_nettype none

module hhlc_back
    import hhlc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_q_valid,
    input  wire t_tok i_tok,
    output logic      o_pop,
    input  wire logic i_out_ready,
    output logic      o_out_valid,
    output logic      o_req_valid,
    output t_err      o_err
);

    typedef enum logic [1:0] {
        PH_NONE  = 2'd0,
        PH_FIRST = 2'd1,
        PH_LATER = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        RL_FIRST   = 3'd0,
        RL_LETTERS = 3'd1,
        RL_GAP     = 3'd2,
        RL_SCAN    = 3'd3,
        RL_MATCHED = 3'd4,
        RL_FAILED  = 3'd5
    } t_rl;

    t_phase     r_phase,     n_phase;
    t_rl        r_rl,        n_rl;
    logic [8:0] r_mask,      n_mask;
    logic [2:0] r_em,        n_em;
    logic       r_colon,     n_colon;
    logic       r_hok,       n_hok;
    logic       r_open,      n_open;
    t_err       r_err_held,  n_err_held;
    logic       r_ended,     n_ended;
    logic       r_out_valid, n_out_valid;
    logic       r_req_valid, n_req_valid;
    t_err       r_err,       n_err;

    // error after judging the open line
    function automatic t_err close_err(input logic open, input t_err err,
                                       input t_phase ph, input t_rl rl,
                                       input logic hok);
        t_err res;
        res = err;
        if (open && err == ERR_NONE) begin
            if (ph == PH_FIRST && rl != RL_MATCHED) begin
                res = ERR_REQ_LINE;
            end else if (ph == PH_LATER && !hok) begin
                res = ERR_HDR_LINE;
            end
        end
        return res;
    endfunction

    function automatic logic email_hit(input logic [2:0] idx, input t_tok tk);
        logic hit;
        case (idx)
            3'd0:    hit = tk.ch_e;
            3'd1:    hit = tk.ch_m;
            3'd2:    hit = tk.ch_a;
            3'd3:    hit = tk.ch_i;
            3'd4:    hit = tk.ch_l;
            3'd5:    hit = tk.ch_eq;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

    assign o_pop       = i_q_valid && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_req_valid = r_req_valid;
    assign o_err       = r_err;

    always_comb begin
        t_err code;
        n_phase     = r_phase;
        n_rl        = r_rl;
        n_mask      = r_mask;
        n_em        = r_em;
        n_colon     = r_colon;
        n_hok       = r_hok;
        n_open      = r_open;
        n_err_held  = r_err_held;
        n_ended     = r_ended;
        n_out_valid = r_out_valid && !i_out_ready;
        n_req_valid = r_req_valid;
        n_err       = r_err;
        code        = ERR_NONE;

        if (o_pop) begin
            if (!r_ended && r_err_held == ERR_NONE) begin
                if (i_tok.nul || i_tok.eol) begin
                    n_err_held = close_err(n_open, n_err_held, n_phase, n_rl, n_hok);
                    n_open     = 1'b0;
                    if (i_tok.nul) begin
                        n_ended = 1'b1;
                    end
                end else begin
                    if (!n_open) begin
                        n_open = 1'b1;
                        if (n_phase == PH_NONE) begin
                            n_phase = PH_FIRST;
                            n_rl    = RL_FIRST;
                            n_mask  = '0;
                        end else begin
                            n_phase = PH_LATER;
                        end
                        n_em    = '0;
                        n_colon = 1'b0;
                        n_hok   = 1'b0;
                    end
                    if (n_phase == PH_FIRST) begin
                        case (n_rl)
                            RL_FIRST: begin
                                n_rl = i_tok.letter ? RL_LETTERS : RL_FAILED;
                            end
                            RL_LETTERS: begin
                                if (i_tok.ws) begin
                                    n_rl = RL_GAP;
                                end else if (!i_tok.letter) begin
                                    n_rl = RL_FAILED;
                                end
                            end
                            RL_GAP: begin
                                if (i_tok.ch_slash) begin
                                    n_rl   = RL_SCAN;
                                    n_mask = '0;
                                end else if (!i_tok.ws) begin
                                    n_rl = RL_FAILED;
                                end
                            end
                            RL_SCAN: begin
                                // shift-and match of ws "HTTP/1" any "1"
                                n_mask[0] = i_tok.ws;
                                n_mask[1] = r_mask[0] & i_tok.ch_h;
                                n_mask[2] = r_mask[1] & i_tok.ch_t;
                                n_mask[3] = r_mask[2] & i_tok.ch_t;
                                n_mask[4] = r_mask[3] & i_tok.ch_p;
                                n_mask[5] = r_mask[4] & i_tok.ch_slash;
                                n_mask[6] = r_mask[5] & i_tok.ch_one;
                                n_mask[7] = r_mask[6];
                                n_mask[8] = r_mask[7] & i_tok.ch_one;
                                if (n_mask[8]) begin
                                    n_rl = RL_MATCHED;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end else if (!n_hok) begin
                        if (n_colon && i_tok.ws) begin
                            n_hok = 1'b1;
                        end
                        n_colon = i_tok.colon;
                        if (email_hit(n_em, i_tok)) begin
                            n_em = n_em + 3'd1;
                        end else begin
                            n_em = i_tok.ch_e ? 3'd1 : 3'd0;
                        end
                        if (n_em == 3'd6) begin
                            n_hok = 1'b1;
                            n_em  = '0;
                        end
                    end
                end
            end

            if (i_tok.last) begin
                code = close_err(n_open, n_err_held, n_phase, n_rl, n_hok);
                if (code == ERR_NONE && n_phase == PH_NONE) begin
                    code = ERR_NO_LINES;
                end
                n_out_valid = 1'b1;
                n_req_valid = (code == ERR_NONE);
                n_err       = code;
                n_phase     = PH_NONE;
                n_rl        = RL_FIRST;
                n_mask      = '0;
                n_em        = '0;
                n_colon     = 1'b0;
                n_hok       = 1'b0;
                n_open      = 1'b0;
                n_err_held  = ERR_NONE;
                n_ended     = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_NONE;
            r_rl        <= RL_FIRST;
            r_mask      <= '0;
            r_em        <= '0;
            r_colon     <= 1'b0;
            r_hok       <= 1'b0;
            r_open      <= 1'b0;
            r_err_held  <= ERR_NONE;
            r_ended     <= 1'b0;
            r_out_valid <= 1'b0;
            r_req_valid <= 1'b0;
            r_err       <= ERR_NONE;
        end else begin
            r_phase     <= n_phase;
            r_rl        <= n_rl;
            r_mask      <= n_mask;
            r_em        <= n_em;
            r_colon     <= n_colon;
            r_hok       <= n_hok;
            r_open      <= n_open;
            r_err_held  <= n_err_held;
            r_ended     <= n_ended;
            r_out_valid <= n_out_valid;
            r_req_valid <= n_req_valid;
            r_err       <= n_err;
        end
    end

endmodule

`default_nettype wire

FILE: tb/hhlc_verdict_checker.sv
// verdict checker for the http header line checker testbench
// follows the request bytes, predicts each verdict word and compares it with the
// master side; depends on hhlc_pkg for the error code type
module hhlc_verdict_checker
    import hhlc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_tvalid,
    input  wire logic       i_s_tready,
    input  wire logic [7:0] i_s_tdata,   // [7:0] data_byte
    input  wire logic       i_s_tlast,   // end_of_request
    input  wire logic       i_m_tvalid,
    input  wire logic       i_m_tready,
    input  wire logic [7:0] i_m_tdata,   // [0] request_valid, [2:1] error_code, rest zero
    output int              o_verdicts_owed,
    output int              o_verdicts_checked,
    output int              o_mismatches
);

    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [47:0] EMAIL_TAG = "email=";

    typedef enum logic [2:0] {
        RQ_FIRST, RQ_LETTERS, RQ_GAP, RQ_SCAN, RQ_MATCHED, RQ_FAILED
    } t_rq_state;

    typedef enum logic [1:0] {LN_NONE, LN_FIRST, LN_LATER} t_line_pos;

    typedef struct packed {
        logic ok;
        t_err code;
    } t_verdict;

    t_line_pos  line_pos;
    t_rq_state  rq_state;
    logic [8:0] tail_hits;
    logic [2:0] email_cnt;
    logic       colon_prev;
    logic       header_pass;
    logic       line_busy;
    logic       text_done;
    t_err       first_err;

    t_verdict verdicts_due[$];
    int       checked_cnt = 0;
    int       mismatch_cnt = 0;

    function automatic bit is_blank(input logic [7:0] c);
        return c == " " || c == 8'h09 || c == 8'h0B || c == 8'h0C;
    endfunction

    function automatic bit is_alpha(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    // tail is blank, "HTTP/1", any byte, "1"
    function automatic bit tail_accepts(input int k, input logic [7:0] c);
        case (k)
            0: return is_blank(c);
            1: return c == "H";
            2, 3: return c == "T";
            4: return c == "P";
            5: return c == "/";
            6, 8: return c == "1";
            default: return 1'b1;
        endcase
    endfunction

    task clear_request();
        line_pos    = LN_NONE;
        rq_state    = RQ_FIRST;
        tail_hits   = '0;
        email_cnt   = '0;
        colon_prev  = 1'b0;
        header_pass = 1'b0;
        line_busy   = 1'b0;
        text_done   = 1'b0;
        first_err   = ERR_NONE;
    endtask

    task start_line();
        line_busy = 1'b1;
        if (line_pos == LN_NONE) begin
            line_pos  = LN_FIRST;
            rq_state  = RQ_FIRST;
            tail_hits = '0;
        end else begin
            line_pos = LN_LATER;
        end
        email_cnt   = '0;
        colon_prev  = 1'b0;
        header_pass = 1'b0;
    endtask

    // judge the open line, keep only the first error
    task end_line();
        if (line_busy) begin
            line_busy = 1'b0;
            if (first_err == ERR_NONE) begin
                if (line_pos == LN_FIRST && rq_state != RQ_MATCHED)
                    first_err = ERR_REQ_LINE;
                else if (line_pos == LN_LATER && !header_pass)
                    first_err = ERR_HDR_LINE;
            end
        end
    endtask

    task request_line_byte(input logic [7:0] c);
        logic [8:0] hits;
        case (rq_state)
            RQ_FIRST: rq_state = is_alpha(c) ? RQ_LETTERS : RQ_FAILED;
            RQ_LETTERS: begin
                if (is_blank(c))
                    rq_state = RQ_GAP;
                else if (!is_alpha(c))
                    rq_state = RQ_FAILED;
            end
            RQ_GAP: begin
                if (c == "/") begin
                    rq_state  = RQ_SCAN;
                    tail_hits = '0;
                end else if (!is_blank(c)) begin
                    rq_state = RQ_FAILED;
                end
            end
            RQ_SCAN: begin
                // every partial match of the tail advances in parallel
                hits = '0;
                for (int k = 0; k < 9; k++)
                    if ((k == 0 || tail_hits[k-1]) && tail_accepts(k, c))
                        hits[k] = 1'b1;
                tail_hits = hits;
                if (hits[8])
                    rq_state = RQ_MATCHED;
            end
            default: ;
        endcase
    endtask

    task header_line_byte(input logic [7:0] c);
        if (!header_pass) begin
            if (colon_prev && is_blank(c))
                header_pass = 1'b1;
            colon_prev = (c == ":");
            if (email_cnt < 6 && c == EMAIL_TAG[47 - 8 * email_cnt -: 8])
                email_cnt = email_cnt + 1;
            else
                email_cnt = (c == "e") ? 3'd1 : 3'd0;
            if (email_cnt >= 6) begin
                header_pass = 1'b1;
                email_cnt   = '0;
            end
        end
    endtask

    task take_byte(input logic [7:0] c, input logic last);
        t_verdict v;
        if (!text_done && first_err == ERR_NONE) begin
            if (c == CH_NUL) begin
                end_line();
                text_done = 1'b1;
            end else if (c == CH_CR || c == CH_LF) begin
                end_line();
            end else begin
                if (!line_busy)
                    start_line();
                if (line_pos == LN_FIRST)
                    request_line_byte(c);
                else
                    header_line_byte(c);
            end
        end
        if (last) begin
            end_line();
            v.code = first_err;
            if (v.code == ERR_NONE && line_pos == LN_NONE)
                v.code = ERR_NO_LINES;
            v.ok = (v.code == ERR_NONE);
            verdicts_due.push_back(v);
            clear_request();
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_verdict want;
        if (!i_rst_n) begin
            clear_request();
            verdicts_due.delete();
        end else begin
            if (i_s_tvalid && i_s_tready)
                take_byte(i_s_tdata, i_s_tlast);
            if (i_m_tvalid && i_m_tready) begin
                if (verdicts_due.size() == 0) begin
                    $error("verdict word 0x%02h with no request pending", i_m_tdata);
                    mismatch_cnt++;
                end else begin
                    want = verdicts_due.pop_front();
                    checked_cnt++;
                    if (i_m_tdata[0] !== want.ok) begin
                        $error("request_valid: expected %0b, got %0b", want.ok, i_m_tdata[0]);
                        mismatch_cnt++;
                    end
                    if (i_m_tdata[2:1] !== want.code) begin
                        $error("error_code: expected %0d, got %0d", want.code,
                               i_m_tdata[2:1]);
                        mismatch_cnt++;
                    end
                    if (i_m_tdata[7:3] !== 5'd0) begin
                        $error("tdata padding: expected 0, got %0h", i_m_tdata[7:3]);
                        mismatch_cnt++;
                    end
                end
            end
        end
        o_verdicts_owed    <= verdicts_due.size();
        o_verdicts_checked <= checked_cnt;
        o_mismatches       <= mismatch_cnt;
    end

endmodule

FILE: tb/http_header_line_checker_test.sv
// top of the http header line checker testbench
// drives request bytes and verdict backpressure, gives the verdict; uses
// hhlc_verdict_checker for prediction and hhlc_pkg through it and the block
module http_header_line_checker_test;

    localparam int IDLE_LIMIT   = 2000;  // cycles with no word moving on either side
    localparam int LONG_HOLD    = 300;   // long output hold-off to fill the block
    localparam int BYTE_TARGET  = 1300;
    localparam int PHASE_COUNT  = 4;
    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_VT  = 8'h0B;
    localparam logic [7:0] CH_FF  = 8'h0C;
    localparam logic [7:0] CH_CR  = 8'h0D;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;    // [7:0] data_byte
    logic       s_tlast = 1'b0;     // end_of_request
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // [0] request_valid, [2:1] error_code, rest zero

    int verdicts_owed;
    int verdicts_checked;
    int mismatches;

    // pacing knobs, percent of cycles; only changed between phases
    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    logic hold_start = 1'b0;
    logic hold_taken = 1'b0;
    int   hold_left  = 0;

    int bytes_sent    = 0;
    int requests_sent = 0;
    int quiet_cycles  = 0;

    logic [7:0] req_text[$];

    http_header_line_checker dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    hhlc_verdict_checker checker_inst (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_s_tvalid         (s_tvalid),
        .i_s_tready         (s_tready),
        .i_s_tdata          (s_tdata),
        .i_s_tlast          (s_tlast),
        .i_m_tvalid         (m_tvalid),
        .i_m_tready         (m_tready),
        .i_m_tdata          (m_tdata),
        .o_verdicts_owed    (verdicts_owed),
        .o_verdicts_checked (verdicts_checked),
        .o_mismatches       (mismatches)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    // master side backpressure; the one long hold is counted here
    always @(posedge clk) begin
        if (hold_start && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left  <= LONG_HOLD;
            m_tready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // watchdog: too long without any word accepted means the block hung
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("** http_header_line_checker: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // offer one byte word, with random idle cycles ahead of it
    task drive_word(input logic [7:0] b, input logic last);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
        bytes_sent++;
    endtask

    // valid stays high between requests so back-to-back words keep flowing
    task send_request();
        for (int i = 0; i < req_text.size(); i++)
            drive_word(req_text[i], i == req_text.size() - 1);
        requests_sent++;
    endtask

    task add_text(input string t);
        for (int i = 0; i < t.len(); i++)
            req_text.push_back(t[i]);
    endtask

    // space, tab, vt or ff
    task add_blanks(input int n);
        for (int i = 0; i < n; i++)
            case ($urandom_range(0, 3))
                0: req_text.push_back(" ");
                1: req_text.push_back(8'h09);
                2: req_text.push_back(CH_VT);
                default: req_text.push_back(CH_FF);
            endcase
    endtask

    task add_breaks();
        int n;
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++)
            req_text.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
    endtask

    task add_letters(input int n);
        for (int i = 0; i < n; i++)
            req_text.push_back(($urandom_range(0, 1) ? "A" : "a") + $urandom_range(0, 25));
    endtask

    // line content without breaks or nul, biased toward colon, 'e' and blanks
    task add_filler(input int n);
        for (int i = 0; i < n; i++)
            case ($urandom_range(0, 7))
                0: add_blanks(1);
                1: req_text.push_back(":");
                2: req_text.push_back("e");
                default: req_text.push_back($urandom_range(8'h21, 8'hFF));
            endcase
    endtask

    task add_request_line();
        add_letters($urandom_range(1, 5));
        add_blanks($urandom_range(1, 2));
        req_text.push_back("/");
        add_filler($urandom_range(0, 4));
        // decoys that half match the tail before the real one
        case ($urandom_range(0, 3))
            0: add_text(" HTTP/1");
            1: add_text("\tHTT");
            default: ;
        endcase
        add_blanks($urandom_range(1, 2));
        add_text("HTTP/1");
        req_text.push_back($urandom_range(0, 1) ? "." : $urandom_range(8'h0E, 8'hFF));
        add_text("1");
        if ($urandom_range(0, 2) == 0)
            add_filler($urandom_range(1, 3));
    endtask

    task add_header_line();
        case ($urandom_range(0, 3))
            0: begin
                // name, colon, blank, value
                add_filler($urandom_range(0, 4));
                req_text.push_back(":");
                add_blanks(1);
                add_filler($urandom_range(0, 4));
            end
            1: begin
                // email tag, sometimes behind a false start
                add_filler($urandom_range(0, 3));
                case ($urandom_range(0, 2))
                    0: add_text("e");
                    1: add_text("ema");
                    default: ;
                endcase
                add_text("email=");
                add_filler($urandom_range(0, 3));
            end
            2: begin
                // near misses that usually fail
                add_text($urandom_range(0, 1) ? "emai=" : "x:y");
                add_filler($urandom_range(0, 3));
            end
            default: add_filler($urandom_range(1, 6));
        endcase
    endtask

    task compose_well_formed();
        int hdrs;
        if ($urandom_range(0, 3) == 0)
            add_breaks();
        add_request_line();
        hdrs = $urandom_range(0, 2);
        for (int i = 0; i < hdrs; i++) begin
            add_breaks();
            add_header_line();
        end
        case ($urandom_range(0, 5))
            0, 1: add_breaks();
            2: begin
                // text ends early; the rest is ignored up to the last word
                req_text.push_back(CH_NUL);
                for (int i = $urandom_range(0, 4); i > 0; i--)
                    req_text.push_back($urandom_range(0, 255));
            end
            default: ;
        endcase
    endtask

    task compose_request();
        int mode;
        int cut;
        req_text.delete();
        mode = $urandom_range(0, 99);
        if (mode < 70) begin
            compose_well_formed();
        end else if (mode < 90) begin
            // broken: one byte clobbered, or the request cut short
            compose_well_formed();
            if ($urandom_range(0, 1)) begin
                req_text[$urandom_range(0, req_text.size() - 1)] = $urandom_range(0, 255);
            end else begin
                cut = $urandom_range(1, req_text.size());
                while (req_text.size() > cut)
                    req_text.delete(req_text.size() - 1);
            end
        end else begin
            // raw noise
            for (int i = $urandom_range(1, 12); i > 0; i--)
                req_text.push_back($urandom_range(0, 255));
        end
    endtask

    initial begin : stimulus
        int ph;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty line only, nul only, a lone high byte
        req_text = '{CH_LF};
        send_request();
        req_text = '{CH_NUL};
        send_request();
        req_text = '{8'hFF};
        send_request();
        // shortest good request with vt and ff as blanks, last word mid-line
        req_text.delete();
        add_text("Z");
        req_text.push_back(CH_VT);
        req_text.push_back("/");
        req_text.push_back(CH_FF);
        add_text("HTTP/1.1");
        send_request();
        // good request line, then a header line of just a colon
        req_text.delete();
        add_text("e\t/ HTTP/1.1\n:");
        send_request();

        // random requests over the pacing phases
        for (ph = 0; ph < PHASE_COUNT; ph++) begin
            case (ph)
                0: begin
                    sender_idle_pct <= 0;
                    recv_stall_pct  <= 0;
                    hold_start      <= 1'b1;  // sender keeps pushing during the hold
                end
                1: begin
                    sender_idle_pct <= 80;
                    recv_stall_pct  <= 0;
                end
                2: begin
                    sender_idle_pct <= 0;
                    recv_stall_pct  <= 80;
                end
                default: begin
                    sender_idle_pct <= 12;
                    recv_stall_pct  <= 12;
                end
            endcase
            while (bytes_sent < (ph + 1) * BYTE_TARGET / PHASE_COUNT
                   || requests_sent < (ph + 1) * 10) begin
                compose_request();
                send_request();
            end
        end
        s_tvalid <= 1'b0;

        // drain outstanding verdicts, then a few cycles for stray words
        do @(posedge clk); while (verdicts_owed != 0);
        repeat (8) @(posedge clk);

        $display("covered %0d request bytes in %0d requests: directed corner cases, random",
                 bytes_sent, requests_sent);
        $display("well-formed, broken and noise requests, four pacing phases, one long hold");
        if (mismatches == 0 && verdicts_checked == requests_sent) begin
            $display("** http_header_line_checker: PASSED **");
        end else begin
            $display("** http_header_line_checker: FAILED **");
        end
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/hhlc_pkg.sv
hw/rtl/hhlc_front.sv
hw/rtl/hhlc_queue.sv
hw/rtl/hhlc_back.sv
hw/rtl/http_header_line_checker.sv
tb/hhlc_verdict_checker.sv
tb/http_header_line_checker_test.sv
